### design/utf8_text_layout_wrap_defines.svh
// Assertion helpers for the layout design's queue
`ifndef UTF8_TEXT_LAYOUT_WRAP_DEFINES_SVH
`define UTF8_TEXT_LAYOUT_WRAP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define UTWR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define UTWR_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

### design/utwr_pkg.sv
package utwr_pkg;

   localparam int unsigned TABLE_DEPTH   = 94;
   localparam int unsigned TABLE_AW      = 7;
   localparam int unsigned QUEUE_DEPTH_D = 4;
   localparam logic [7:0]  FIRST_PRINT   = 8'd33;
   localparam logic [7:0]  LAST_PRINT    = 8'd126;
   localparam logic [31:0] CP_SPACE      = 32'd32;
   localparam logic [31:0] CP_TAB        = 32'd9;
   localparam logic [31:0] CP_LF         = 32'd10;
   localparam logic [31:0] CP_CR         = 32'd13;
   localparam logic [1:0]  CONT_TAG      = 2'b10;
   localparam logic        REQ_TABLE     = 1'b0;
   localparam logic [1:0]  STEP_FIRST    = 2'd0;
   localparam logic [1:0]  STEP_SECOND   = 2'd1;
   localparam logic [1:0]  STEP_FINAL    = 2'd2;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_WRAP_WIDTH  = 3'd2,
      CSR_WRAP_HEIGHT = 3'd3,
      CSR_CELL_WIDTH  = 3'd4,
      CSR_LINE_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] text_byte;
      logic       last_byte;
      logic [6:0] table_index;
      logic [7:0] table_width;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] glyph_x;
      logic signed [15:0] glyph_y;
      logic [31:0]        code_point;
      logic [7:0]         advance;
      logic               drawable;
      logic               finished;
      logic [31:0]        end_offset;
      logic               last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [15:0]        wrap_width;
      logic [15:0]        wrap_height;
      logic [7:0]         cell_width;
      logic [7:0]         line_height;
   } cfg_type;

   // One decoded text byte: up to two finished characters and a text end
   typedef struct packed {
      logic        c1_vld;
      logic [31:0] cp1;
      logic [31:0] end1;
      logic [7:0]  w1;
      logic        t1;
      logic        c2_vld;
      logic [31:0] cp2;
      logic [31:0] end2;
      logic [7:0]  w2;
      logic        t2;
      logic        last;
   } event_type;

   // Code of a character from its lead byte, continuation bits and count
   function automatic logic [31:0] cp_of(logic [7:0] lead, logic [31:0] acc, logic [7:0] cnt);
      logic [7:0]  mask;
      logic [31:0] lp;
      mask = 8'h3F >> cnt[2:0];
      lp   = {24'd0, mask & lead};
      if (cnt == 8'd0) begin
         cp_of = {24'd0, lead};
      end else begin
         unique case (cnt)
            8'd1:    cp_of = acc | (lp << 6);
            8'd2:    cp_of = acc | (lp << 12);
            8'd3:    cp_of = acc | (lp << 18);
            8'd4:    cp_of = acc | (lp << 24);
            8'd5:    cp_of = acc | (lp << 30);
            default: cp_of = acc;
         endcase
      end
   endfunction

   function automatic logic in_table(logic [31:0] cp);
      in_table = (cp >= {24'd0, FIRST_PRINT}) && (cp <= {24'd0, LAST_PRINT});
   endfunction

endpackage

### design/utwr_front.sv
module utwr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  utwr_pkg::req_word_type req_word,
   output logic                  ev_vld,
   output utwr_pkg::event_type   ev_word,
   input  logic                  q_full
);

   logic [7:0]  table_mem [utwr_pkg::TABLE_DEPTH];
   logic [7:0]  lead_ff, lead_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [31:0] seen_ff, seen_in;
   utwr_pkg::event_type ev_ff, ev_in;
   logic        vld_ff, vld_in;
   logic [7:0]  rd1_ff, rd2_ff;
   logic        accept, text, cont, push_out;
   logic [utwr_pkg::TABLE_AW-1:0] a1, a2;

   assign req_full = vld_ff && q_full;
   assign accept   = req_push && !req_full;
   assign text     = req_word.req_type != utwr_pkg::REQ_TABLE;
   assign push_out = vld_ff && !q_full;
   assign cont     = pend_ff && (req_word.text_byte[7:6] == utwr_pkg::CONT_TAG);

   // Decode one byte: extend the pending character or start a new one
   always_comb begin
      ev_in   = '0;
      lead_in = lead_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      pend_in = 1'b1;
      if (cont) begin
         acc_in = {acc_ff[25:0], req_word.text_byte[5:0]};
         cnt_in = cnt_ff + 8'd1;
      end else begin
         ev_in.c1_vld = pend_ff;
         ev_in.cp1    = utwr_pkg::cp_of(lead_ff, acc_ff, cnt_ff);
         ev_in.end1   = seen_ff;
         lead_in      = req_word.text_byte;
         acc_in       = '0;
         cnt_in       = '0;
      end
      seen_in      = seen_ff + 32'd1;
      ev_in.t1     = utwr_pkg::in_table(ev_in.cp1);
      ev_in.last   = req_word.last_byte;
      ev_in.c2_vld = req_word.last_byte;
      ev_in.cp2    = utwr_pkg::cp_of(lead_in, acc_in, cnt_in);
      ev_in.end2   = seen_in;
      ev_in.t2     = utwr_pkg::in_table(ev_in.cp2);
      // restart after the final byte of a text
      if (req_word.last_byte) begin
         lead_in = '0;
         acc_in  = '0;
         cnt_in  = '0;
         pend_in = 1'b0;
         seen_in = '0;
      end
   end

   assign a1 = ev_in.cp1[utwr_pkg::TABLE_AW-1:0] - utwr_pkg::FIRST_PRINT[utwr_pkg::TABLE_AW-1:0];
   assign a2 = ev_in.cp2[utwr_pkg::TABLE_AW-1:0] - utwr_pkg::FIRST_PRINT[utwr_pkg::TABLE_AW-1:0];

   // Hold the stage word until the queue takes it
   always_comb begin
      vld_in = vld_ff;
      if (push_out) vld_in = 1'b0;
      if (accept && text && (ev_in.c1_vld || ev_in.last)) vld_in = 1'b1;
   end

   // Width table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (accept && !text &&
          req_word.table_index < utwr_pkg::TABLE_AW'(utwr_pkg::TABLE_DEPTH)) begin
         table_mem[req_word.table_index] <= req_word.table_width;
      end
      if (accept && text) begin
         rd1_ff <= (a1 < utwr_pkg::TABLE_AW'(utwr_pkg::TABLE_DEPTH)) ? table_mem[a1] : 8'd0;
         rd2_ff <= (a2 < utwr_pkg::TABLE_AW'(utwr_pkg::TABLE_DEPTH)) ? table_mem[a2] : 8'd0;
         ev_ff  <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
         seen_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (accept && text) begin
            lead_ff <= lead_in;
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_in;
            pend_ff <= pend_in;
            seen_ff <= seen_in;
         end
      end
   end

   always_comb begin
      ev_word    = ev_ff;
      ev_word.w1 = rd1_ff;
      ev_word.w2 = rd2_ff;
   end
   assign ev_vld = push_out;

endmodule

### design/utwr_fifo.sv
`include "utf8_text_layout_wrap_defines.svh"
module utwr_fifo #(
   parameter int unsigned DEPTH = utwr_pkg::QUEUE_DEPTH_D
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utwr_pkg::event_type push_word,
   output logic                full,
   input  logic                pop,
   output logic                head_vld,
   output utwr_pkg::event_type head_word
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   utwr_pkg::event_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == CW'(DEPTH);
   assign head_vld  = cnt_ff != '0;
   assign head_word = slot_ff[rd_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `UTWR_ASSERT_ALWAYS(a_no_overflow, !(push && full), "word pushed into full queue")
   `UTWR_ASSERT_ALWAYS(a_no_underflow, !(pop && !head_vld), "word popped from empty queue")
   `UTWR_ASSERT_NEXT(a_count_up, push && !pop, cnt_ff == $past(cnt_ff) + CW'(1), "count lost a push")

endmodule

### design/utwr_back.sv
module utwr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  utwr_pkg::cfg_type      cfg,
   input  logic                   head_vld,
   input  utwr_pkg::event_type    head_word,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output utwr_pkg::rsp_word_type rsp_word
);

   logic [15:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [7:0]  prev_ff, prev_in;
   logic [31:0] comm_ff, comm_in;
   logic        run_ff, run_in;
   logic [1:0]  step_ff, step_in;
   utwr_pkg::rsp_word_type out_ff, res;
   logic        out_vld_ff;

   logic sel1, sel2, self, work, fire, done, more, lf, wrapc, hstop, is_nul;
   logic [31:0] cp, fin_off;
   logic [7:0]  wv, adv;
   logic        tr;
   logic [15:0] px1, px2, py2;
   logic signed [18:0] xsum, ysum;

   // Pick the first step of the word still to be carried out
   assign sel1 = (step_ff == utwr_pkg::STEP_FIRST) && head_word.c1_vld;
   assign sel2 = !sel1 && (step_ff != utwr_pkg::STEP_FINAL) && head_word.c2_vld;
   assign self = !sel1 && !sel2 && head_word.last;
   assign work = head_vld && run_ff && (sel1 || sel2 || self);
   assign fire = work && (!out_vld_ff || rsp_pop);

   assign cp      = sel1 ? head_word.cp1 : head_word.cp2;
   assign wv      = sel1 ? head_word.w1 : head_word.w2;
   assign tr      = sel1 ? head_word.t1 : head_word.t2;
   assign fin_off = sel1 ? head_word.end1 : head_word.end2;
   assign is_nul  = cp == '0;
   assign lf      = cp == utwr_pkg::CP_LF;
   assign px1     = pen_x_ff + {8'd0, prev_ff};

   // Advance of the character
   always_comb begin
      priority if (cp == utwr_pkg::CP_SPACE) adv = cfg.cell_width >> 1;
      else if (cp == utwr_pkg::CP_TAB)        adv = {cfg.cell_width[6:0], 1'b0};
      else if (lf || cp == utwr_pkg::CP_CR)   adv = 8'd0;
      else if (tr)                            adv = wv;
      else                                    adv = cfg.cell_width;
   end

   // Line and block limit checks in full signed arithmetic
   assign xsum  = 19'(signed'(px1)) + signed'({11'd0, adv}) - 19'(signed'(cfg.origin_x));
   assign wrapc = lf || (cfg.wrap_width != '0 && xsum > signed'({3'd0, cfg.wrap_width}));
   assign px2   = wrapc ? cfg.origin_x : px1;
   assign py2   = wrapc ? pen_y_ff + {8'd0, cfg.line_height} : pen_y_ff;
   assign ysum  = 19'(signed'(py2)) + signed'({11'd0, cfg.line_height})
                  - 19'(signed'(cfg.origin_y));
   assign hstop = cfg.wrap_height != '0 && ysum > signed'({3'd0, cfg.wrap_height});
   assign more  = sel1 ? (head_word.c2_vld || head_word.last) : head_word.last;

   // Place the character or give the final report
   always_comb begin
      res      = '0;
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      prev_in  = prev_ff;
      comm_in  = comm_ff;
      run_in   = run_ff;
      done     = 1'b1;
      priority if (self || is_nul) begin
         pen_x_in = px1;
         prev_in  = 8'd0;
         run_in   = 1'b0;
      end else if (hstop) begin
         pen_x_in = px2;
         pen_y_in = py2;
         if (lf) begin
            comm_in = fin_off;
            prev_in = adv;
         end else begin
            prev_in = 8'd0;
         end
         run_in = 1'b0;
      end else begin
         pen_x_in       = px2;
         pen_y_in       = py2;
         comm_in        = fin_off;
         prev_in        = adv;
         done           = !more;
         res.code_point = cp;
         res.advance    = adv;
         res.drawable   = !(cp == utwr_pkg::CP_SPACE || cp == utwr_pkg::CP_TAB ||
                            lf || cp == utwr_pkg::CP_CR);
      end
      res.glyph_x     = pen_x_in;
      res.glyph_y     = pen_y_in;
      res.finished    = !run_in;
      res.end_offset  = comm_in;
      res.last_of_run = done;
   end

   assign q_pop   = head_vld && (!work || (fire && done));
   assign step_in = sel1 ? utwr_pkg::STEP_SECOND : utwr_pkg::STEP_FINAL;

   always_ff @(posedge clock) begin
      if (fire) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         prev_ff    <= '0;
         comm_ff    <= '0;
         run_ff     <= 1'b1;
         step_ff    <= utwr_pkg::STEP_FIRST;
         out_vld_ff <= 1'b0;
      end else begin
         if (fire) out_vld_ff <= 1'b1;
         else if (rsp_pop) out_vld_ff <= 1'b0;
         // drop the word; restart the text after its final byte
         if (q_pop && head_word.last) begin
            pen_x_ff <= cfg.origin_x;
            pen_y_ff <= cfg.origin_y;
            prev_ff  <= '0;
            comm_ff  <= '0;
            run_ff   <= 1'b1;
         end else if (fire) begin
            pen_x_ff <= pen_x_in;
            pen_y_ff <= pen_y_in;
            prev_ff  <= prev_in;
            comm_ff  <= comm_in;
            run_ff   <= run_in;
         end
         if (q_pop) step_ff <= utwr_pkg::STEP_FIRST;
         else if (fire) step_ff <= step_in;
      end
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

### design/utf8_text_layout_wrap.sv
// A text byte's results pass through the decode register, the queue and the result register.
// Throughput: one byte per cycle while full is low; a byte that causes more than one result
// holds the layout stage for each, and a QUEUE_DEPTH-word queue (four by default) between
// decoder and layout absorbs the difference. Width table writes give no result.
// Reset (synchronous, active high) empties the queue and result register, sets the pen to
// the origin and the registers to their defaults; the width table is not cleared.
module utf8_text_layout_wrap #(
   parameter int unsigned QUEUE_DEPTH = utwr_pkg::QUEUE_DEPTH_D
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  utwr_pkg::req_word_type req_word,
   output logic                   empty,
   input  logic                   pop,
   output utwr_pkg::rsp_word_type rsp_word,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   utwr_pkg::cfg_type   cfg_ff;
   utwr_pkg::event_type ev_word, head_word;
   logic ev_vld, q_full, q_pop, head_vld;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff             <= '0;
         cfg_ff.cell_width  <= 8'd8;
         cfg_ff.line_height <= 8'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            utwr_pkg::CSR_ORIGIN_X:    cfg_ff.origin_x    <= csr_wdata;
            utwr_pkg::CSR_ORIGIN_Y:    cfg_ff.origin_y    <= csr_wdata;
            utwr_pkg::CSR_WRAP_WIDTH:  cfg_ff.wrap_width  <= csr_wdata;
            utwr_pkg::CSR_WRAP_HEIGHT: cfg_ff.wrap_height <= csr_wdata;
            utwr_pkg::CSR_CELL_WIDTH:  cfg_ff.cell_width  <= csr_wdata[7:0];
            utwr_pkg::CSR_LINE_HEIGHT: cfg_ff.line_height <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   utwr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_full (full),
      .req_word (req_word),
      .ev_vld   (ev_vld),
      .ev_word  (ev_word),
      .q_full   (q_full)
   );

   utwr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_vld),
      .push_word (ev_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_vld  (head_vld),
      .head_word (head_word)
   );

   utwr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_vld  (head_vld),
      .head_word (head_word),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_word  (rsp_word)
   );

endmodule
